// File: rtl/wcfr_pkg.sv
// Shared types and constants of the wireless CAN frame receiver.
// Used by the front end, command queue, back end and top level; no dependencies.
`timescale 1ns / 1ps

package wcfr_pkg;

   localparam logic [7:0]  PREAMBLE     = 8'h55;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [7:0]  TYPE_CAN     = 8'h00;
   localparam logic [7:0]  TYPE_KEEP    = 8'h10;
   localparam logic [7:0]  TYPE_TIME    = 8'h11;
   localparam logic [7:0]  TYPE_DIAG0   = 8'h12;
   localparam logic [7:0]  TYPE_DIAG1   = 8'h13;
   localparam logic [7:0]  TYPE_DIAG2   = 8'h14;
   localparam logic [7:0]  TYPE_ABORT   = 8'h15;
   localparam logic [7:0]  IND_BASE     = 8'h80;
   localparam logic [15:0] TIME_OVERRUN = 16'hFFFF;
   localparam logic [3:0]  MAX_DLEN     = 4'd8;

   typedef enum logic [3:0] {
      EV_CAN      = 4'd0,
      EV_PREAMBLE = 4'd1,
      EV_CRC      = 4'd2,
      EV_SEQ      = 4'd3,
      EV_TYPE     = 4'd4,
      EV_PAYLOAD  = 4'd5,
      EV_TELEGRAM = 4'd6,
      EV_ABORT    = 4'd7,
      EV_DIAG     = 4'd8
   } ev_code_type;

   typedef struct packed {
      logic        is_frame;
      ev_code_type code;
      logic        seq_bad;
      logic [7:0]  ftype;
      logic [7:0]  flen;
   } cmd_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } pwr_type;

   typedef struct packed {
      logic [6:0]  iface;
      logic [28:0] can_id;
      logic        extended;
      logic        remote;
      logic [3:0]  data_len;
      logic [63:0] data_bytes;
      logic        has_time;
      logic [47:0] time_ticks;
      ev_code_type event_code;
      logic [31:0] abort_code;
      logic        last;
   } rsl_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/wcfr_req_if.sv
// Byte channel into the receiver: valid/ready handshake with one stream byte a beat.
// Standalone; no dependencies.
`timescale 1ns / 1ps

interface wcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/wcfr_rsp_if.sv
// Result channel out of the receiver: valid/ready handshake, one CAN frame or event a beat.
// Standalone; no dependencies.
`timescale 1ns / 1ps

interface wcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  iface;
   logic [28:0] can_id;
   logic        extended;
   logic        remote;
   logic [3:0]  data_len;
   logic [63:0] data_bytes;
   logic        has_time;
   logic [47:0] time_ticks;
   logic [3:0]  event_code;
   logic [31:0] abort_code;
   logic        last;

   modport source (output valid, output iface, output can_id, output extended, output remote,
                   output data_len, output data_bytes, output has_time, output time_ticks,
                   output event_code, output abort_code, output last, input ready);
   modport sink   (input valid, input iface, input can_id, input extended, input remote,
                   input data_len, input data_bytes, input has_time, input time_ticks,
                   input event_code, input abort_code, input last, output ready);
endinterface

// File: rtl/wireless_can_frame_receiver.sv
// Wireless CAN frame receiver, receive side: top level with configuration register.
// Depends on wcfr_pkg, wcfr_req_if, wcfr_rsp_if, wcfr_front, wcfr_cmdq, wcfr_back.
//
// Takes one stream byte a beat and normally accepts a byte every cycle, unless the
// command queue is full; at the second CRC byte of a good frame the input stalls until
// the back end has finished that frame, longer when the result channel back-pressures.
// Results leave through a registered output with one staged result behind it; last
// marks the final result of a byte. Per-interface time starts at zero after reset
// through per-entry valid bits, so no clearing pass.
`timescale 1ns / 1ps

module wireless_can_frame_receiver #(
   parameter int unsigned PAYLOAD_BYTES = 128,
   parameter int unsigned NUM_IFACES    = 127
) (
   input  logic       clock,
   input  logic       reset,
   wcfr_req_if.sink   req_chan,
   wcfr_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import wcfr_pkg::*;

   logic [6:0] own_ff, own_in;
   cmd_type    fcmd;
   cmd_type    qcmd;
   pwr_type    pwr;
   rsl_type    rsl;
   logic       push, pop, full, empty, done;

   assign own_in = csr_wr_en ? csr_wr_data : own_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= 7'd1;
      end else begin
         own_ff <= own_in;
      end
   end

   wcfr_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_vld   (req_chan.valid),
      .byte_rdy   (req_chan.ready),
      .byte_data  (req_chan.rx_byte),
      .cmd        (fcmd),
      .cmd_push   (push),
      .cmd_full   (full),
      .frame_done (done),
      .pwr        (pwr)
   );

   wcfr_cmdq u_cmdq (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_cmd (fcmd),
      .pop    (pop),
      .rd_cmd (qcmd),
      .full   (full),
      .empty  (empty)
   );

   wcfr_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES), .NUM_IFACES(NUM_IFACES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .own_iface  (own_ff),
      .pwr        (pwr),
      .cmd        (qcmd),
      .cmd_empty  (empty),
      .cmd_pop    (pop),
      .frame_done (done),
      .rsp_data   (rsl),
      .rsp_vld    (rsp_chan.valid),
      .rsp_rdy    (rsp_chan.ready)
   );

   assign rsp_chan.iface      = rsl.iface;
   assign rsp_chan.can_id     = rsl.can_id;
   assign rsp_chan.extended   = rsl.extended;
   assign rsp_chan.remote     = rsl.remote;
   assign rsp_chan.data_len   = rsl.data_len;
   assign rsp_chan.data_bytes = rsl.data_bytes;
   assign rsp_chan.has_time   = rsl.has_time;
   assign rsp_chan.time_ticks = rsl.time_ticks;
   assign rsp_chan.event_code = rsl.event_code;
   assign rsp_chan.abort_code = rsl.abort_code;
   assign rsp_chan.last       = rsl.last;

endmodule

// File: rtl/wcfr_front.sv
// Front end: deframes the byte stream, checks CRC and sequence, writes payload bytes
// and queues one command per frame or framing error. Depends on wcfr_pkg.
`timescale 1ns / 1ps

module wcfr_front #(
   parameter int unsigned PAYLOAD_BYTES = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_vld,
   output logic             byte_rdy,
   input  logic [7:0]       byte_data,
   output wcfr_pkg::cmd_type cmd,
   output logic             cmd_push,
   input  logic             cmd_full,
   input  logic             frame_done,
   output wcfr_pkg::pwr_type pwr
);
   import wcfr_pkg::*;

   typedef enum logic [6:0] {
      F_PRE  = 7'b0000001,
      F_LEN  = 7'b0000010,
      F_SEQ  = 7'b0000100,
      F_TYP  = 7'b0001000,
      F_PAY  = 7'b0010000,
      F_CRCL = 7'b0100000,
      F_CRCH = 7'b1000000
   } fst_type;

   fst_type     st_ff, st_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  typ_ff, typ_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crcl_ff, crcl_in;
   logic [7:0]  exp_ff, exp_in;
   logic [7:0]  k_ff, k_in;
   logic        wait_ff, wait_in;
   logic        acc;

   assign byte_rdy = !cmd_full && !wait_ff;
   assign acc      = byte_vld && byte_rdy;

   always_comb begin
      st_in    = st_ff;
      len_in   = len_ff;
      seq_in   = seq_ff;
      typ_in   = typ_ff;
      crc_in   = crc_ff;
      crcl_in  = crcl_ff;
      exp_in   = exp_ff;
      k_in     = k_ff;
      wait_in  = wait_ff;
      cmd_push = 1'b0;
      cmd      = '0;
      pwr      = '0;
      if (frame_done) begin
         wait_in = 1'b0;
      end
      if (acc) begin
         case (st_ff)
            F_PRE: begin
               if (byte_data != PREAMBLE) begin
                  cmd_push = 1'b1;
                  cmd.code = EV_PREAMBLE;
               end else begin
                  crc_in = crc_byte(CRC_INIT, byte_data);
                  st_in  = F_LEN;
               end
            end
            F_LEN: begin
               len_in = byte_data;
               if (byte_data > 8'(PAYLOAD_BYTES)) begin
                  cmd_push = 1'b1;
                  cmd.code = EV_PAYLOAD;
                  st_in    = F_PRE;
               end else begin
                  crc_in = crc_byte(crc_ff, byte_data);
                  st_in  = F_SEQ;
               end
            end
            F_SEQ: begin
               seq_in = byte_data;
               crc_in = crc_byte(crc_ff, byte_data);
               st_in  = F_TYP;
            end
            F_TYP: begin
               typ_in = byte_data;
               crc_in = crc_byte(crc_ff, byte_data);
               k_in   = 8'd0;
               st_in  = (len_ff == 8'd0) ? F_CRCL : F_PAY;
            end
            F_PAY: begin
               pwr.en   = 1'b1;
               pwr.addr = k_ff;
               pwr.data = byte_data;
               crc_in   = crc_byte(crc_ff, byte_data);
               k_in     = 8'(k_ff + 8'd1);
               if (8'(k_ff + 8'd1) == len_ff) begin
                  st_in = F_CRCL;
               end
            end
            F_CRCL: begin
               crcl_in = byte_data;
               st_in   = F_CRCH;
            end
            F_CRCH: begin
               cmd_push = 1'b1;
               st_in    = F_PRE;
               if ({byte_data, crcl_ff} == crc_ff) begin
                  cmd.is_frame = 1'b1;
                  cmd.code     = EV_CAN;
                  cmd.seq_bad  = (seq_ff != exp_ff);
                  cmd.ftype    = typ_ff;
                  cmd.flen     = len_ff;
                  exp_in       = 8'(seq_ff + 8'd1);
                  wait_in      = 1'b1;
               end else begin
                  cmd.code = EV_CRC;
               end
            end
            default: begin
               st_in = F_PRE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= F_PRE;
         len_ff  <= 8'd0;
         seq_ff  <= 8'd0;
         typ_ff  <= 8'd0;
         crc_ff  <= CRC_INIT;
         crcl_ff <= 8'd0;
         exp_ff  <= 8'd0;
         k_ff    <= 8'd0;
         wait_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         len_ff  <= len_in;
         seq_ff  <= seq_in;
         typ_ff  <= typ_in;
         crc_ff  <= crc_in;
         crcl_ff <= crcl_in;
         exp_ff  <= exp_in;
         k_ff    <= k_in;
         wait_ff <= wait_in;
      end
   end

endmodule

// File: rtl/wcfr_cmdq.sv
// Two-entry command queue between front end and back end.
// Depends on wcfr_pkg.
`timescale 1ns / 1ps

module wcfr_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wcfr_pkg::cmd_type wr_cmd,
   input  logic              pop,
   output wcfr_pkg::cmd_type rd_cmd,
   output logic              full,
   output logic              empty
);
   import wcfr_pkg::*;

   cmd_type    ent_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full   = (cnt_ff == 2'd2);
   assign empty  = (cnt_ff == 2'd0);
   assign rd_cmd = ent_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = !wp_ff;
      end
      if (pop) begin
         rp_in = !rp_ff;
      end
      if (push && !pop) begin
         cnt_in = 2'(cnt_ff + 2'd1);
      end else if (pop && !push) begin
         cnt_in = 2'(cnt_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/wcfr_back.sv
// Back end: executes queued commands, parses CAN telegrams from the payload memory,
// keeps per-interface time and drives the result register. Depends on wcfr_pkg.
`timescale 1ns / 1ps

module wcfr_back #(
   parameter int unsigned PAYLOAD_BYTES = 128,
   parameter int unsigned NUM_IFACES    = 127
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        own_iface,
   input  wcfr_pkg::pwr_type pwr,
   input  wcfr_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              frame_done,
   output wcfr_pkg::rsl_type rsp_data,
   output logic              rsp_vld,
   input  logic              rsp_rdy
);
   import wcfr_pkg::*;

   localparam int unsigned PA_W        = $clog2(PAYLOAD_BYTES);
   localparam int unsigned TI_W        = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
   localparam int unsigned MAX_RESULTS = PAYLOAD_BYTES / 3 + 2;
   localparam int unsigned RC_W        = $clog2(MAX_RESULTS + 1);

   typedef enum logic [14:0] {
      B_IDLE  = 15'b000000000000001,
      B_EV    = 15'b000000000000010,
      B_FIN   = 15'b000000000000100,
      B_SEQ   = 15'b000000000001000,
      B_DISP  = 15'b000000000010000,
      B_PCHK  = 15'b000000000100000,
      B_PFET  = 15'b000000001000000,
      B_PUSE  = 15'b000000010000000,
      B_DELIV = 15'b000000100000000,
      B_TRD   = 15'b000001000000000,
      B_TUPD  = 15'b000010000000000,
      B_CEMIT = 15'b000100000000000,
      B_MFET  = 15'b001000000000000,
      B_MUSE  = 15'b010000000000000,
      B_MDEC  = 15'b100000000000000
   } bst_type;

   typedef enum logic [4:0] {
      FD_DLC  = 5'b00001,
      FD_NIF  = 5'b00010,
      FD_ID   = 5'b00100,
      FD_DATA = 5'b01000,
      FD_TS   = 5'b10000
   } fld_type;

   bst_type     st_ff, st_in;
   fld_type     fld_ff, fld_in;
   logic [3:0]  need_ff, need_in;
   logic [2:0]  fpos_ff, fpos_in;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  typ_ff, typ_in;
   logic [2:0]  mlen_ff, mlen_in;
   logic [39:0] mg_ff, mg_in;
   logic [7:0]  dlc_ff, dlc_in;
   logic [7:0]  nif_ff, nif_in;
   logic [31:0] id_ff, id_in;
   logic [63:0] data_ff, data_in;
   logic [15:0] ts_ff, ts_in;
   logic [47:0] tsum_ff, tsum_in;
   logic        temit_ff, temit_in;
   ev_code_type evc_ff, evc_in;
   logic [31:0] ac_ff, ac_in;
   logic        frm_ff, frm_in;

   logic [7:0]  pmem [PAYLOAD_BYTES];
   logic [7:0]  pq_ff;
   logic [47:0] tmem [NUM_IFACES];
   logic [47:0] tq_ff;
   logic [NUM_IFACES-1:0] tvld_ff;
   logic        tvq_ff;
   logic [7:0]  nif_m1;
   logic [TI_W-1:0] ti;
   logic        t_wr;

   rsl_type     hold_ff, hold_in;
   logic        hold_vld_ff, hold_vld_in;
   rsl_type     out_ff, out_in;
   logic        out_vld_ff, out_vld_in;
   logic [RC_W-1:0] rcnt_ff, rcnt_in;

   logic        can_emit;
   logic        emit_go;
   logic        fin_go;
   rsl_type     emit_val;
   logic        nif_ok;

   assign nif_m1   = 8'(nif_ff - 8'd1);
   assign ti       = nif_m1[TI_W-1:0];
   assign nif_ok   = (nif_ff != 8'd0) && (nif_ff <= 8'(NUM_IFACES));
   assign can_emit = !hold_vld_ff || !out_vld_ff || rsp_rdy;
   assign rsp_data = out_ff;
   assign rsp_vld  = out_vld_ff;

   always_comb begin
      logic [7:0]  b;
      logic        fdone;
      logic [47:0] tcur;
      logic [7:0]  mnif;
      st_in      = st_ff;
      fld_in     = fld_ff;
      need_in    = need_ff;
      fpos_in    = fpos_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      typ_in     = typ_ff;
      mlen_in    = mlen_ff;
      mg_in      = mg_ff;
      dlc_in     = dlc_ff;
      nif_in     = nif_ff;
      id_in      = id_ff;
      data_in    = data_ff;
      ts_in      = ts_ff;
      tsum_in    = tsum_ff;
      temit_in   = temit_ff;
      evc_in     = evc_ff;
      ac_in      = ac_ff;
      frm_in     = frm_ff;
      cmd_pop    = 1'b0;
      frame_done = 1'b0;
      emit_go    = 1'b0;
      fin_go     = 1'b0;
      emit_val   = '0;
      t_wr       = 1'b0;
      b          = pq_ff;
      fdone      = 1'b0;
      tcur       = tvq_ff ? tq_ff : 48'd0;
      mnif       = mg_ff[7:0];
      case (st_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               idx_in  = 8'd0;
               len_in  = cmd.flen;
               typ_in  = cmd.ftype;
               ac_in   = 32'd0;
               evc_in  = cmd.code;
               frm_in  = cmd.is_frame;
               fld_in  = FD_DLC;
               if (!cmd.is_frame) begin
                  st_in = B_EV;
               end else if (cmd.seq_bad) begin
                  st_in = B_SEQ;
               end else begin
                  st_in = B_DISP;
               end
            end
         end
         B_SEQ: begin
            if (can_emit) begin
               emit_go             = 1'b1;
               emit_val.event_code = EV_SEQ;
               st_in               = B_DISP;
            end
         end
         B_DISP: begin
            case (typ_ff)
               TYPE_CAN: begin
                  st_in = B_PCHK;
               end
               TYPE_KEEP, TYPE_TIME: begin
                  if (len_ff == 8'd0) begin
                     evc_in = EV_PAYLOAD;
                     st_in  = B_EV;
                  end else begin
                     mlen_in = 3'd1;
                     st_in   = B_MFET;
                  end
               end
               TYPE_DIAG0, TYPE_DIAG1, TYPE_DIAG2: begin
                  evc_in = EV_DIAG;
                  st_in  = B_EV;
               end
               TYPE_ABORT: begin
                  if (len_ff < 8'd5) begin
                     evc_in = EV_PAYLOAD;
                     st_in  = B_EV;
                  end else begin
                     mlen_in = 3'd5;
                     st_in   = B_MFET;
                  end
               end
               default: begin
                  evc_in = EV_TYPE;
                  st_in  = B_EV;
               end
            endcase
         end
         B_MFET: begin
            st_in = B_MUSE;
         end
         B_MUSE: begin
            mg_in[{idx_ff[2:0], 3'b000} +: 8] = b;
            idx_in = 8'(idx_ff + 8'd1);
            st_in  = (3'(idx_ff[2:0] + 3'd1) == mlen_ff) ? B_MDEC : B_MFET;
         end
         B_MDEC: begin
            st_in = B_FIN;
            case (typ_ff)
               TYPE_KEEP: begin
                  if (mnif <= IND_BASE) begin
                     evc_in = EV_PAYLOAD;
                     st_in  = B_EV;
                  end
               end
               TYPE_TIME: begin
                  if (mnif == 8'd0 || mnif > 8'(NUM_IFACES)) begin
                     evc_in = EV_PAYLOAD;
                     st_in  = B_EV;
                  end else begin
                     nif_in   = mnif;
                     ts_in    = TIME_OVERRUN;
                     temit_in = 1'b0;
                     st_in    = B_TRD;
                  end
               end
               TYPE_ABORT: begin
                  if (mnif <= IND_BASE) begin
                     evc_in = EV_PAYLOAD;
                     st_in  = B_EV;
                  end else if (mnif == {1'b1, own_iface} && mg_ff[39:8] != 32'd0) begin
                     evc_in = EV_ABORT;
                     ac_in  = mg_ff[39:8];
                     st_in  = B_EV;
                  end
               end
               default: begin
                  st_in = B_FIN;
               end
            endcase
         end
         B_PCHK: begin
            if (idx_ff == len_ff) begin
               if (fld_ff == FD_DLC) begin
                  st_in = B_FIN;
               end else begin
                  evc_in = EV_TELEGRAM;
                  st_in  = B_EV;
               end
            end else begin
               st_in = B_PFET;
            end
         end
         B_PFET: begin
            st_in = B_PUSE;
         end
         B_PUSE: begin
            idx_in  = 8'(idx_ff + 8'd1);
            fpos_in = 3'(fpos_ff + 3'd1);
            st_in   = B_PCHK;
            case (fld_ff)
               FD_DLC: begin
                  dlc_in  = b;
                  id_in   = 32'd0;
                  data_in = 64'd0;
                  ts_in   = 16'd0;
                  nif_in  = 8'd1;
                  fpos_in = 3'd0;
                  if (b[3:0] > MAX_DLEN) begin
                     evc_in = EV_TELEGRAM;
                     st_in  = B_EV;
                  end else if (b[7]) begin
                     fld_in  = FD_NIF;
                     need_in = 4'd1;
                  end else begin
                     fld_in  = FD_ID;
                     need_in = b[5] ? 4'd4 : 4'd2;
                  end
               end
               FD_NIF: begin
                  nif_in  = b;
                  fld_in  = FD_ID;
                  need_in = dlc_ff[5] ? 4'd4 : 4'd2;
                  fpos_in = 3'd0;
               end
               FD_ID: begin
                  id_in[{fpos_ff[1:0], 3'b000} +: 8] = b;
                  fdone = (4'(fpos_ff) + 4'd1 == need_ff);
               end
               FD_DATA: begin
                  data_in[{fpos_ff, 3'b000} +: 8] = b;
                  fdone = (4'(fpos_ff) + 4'd1 == need_ff);
               end
               FD_TS: begin
                  ts_in[{fpos_ff[0], 3'b000} +: 8] = b;
                  fdone = (4'(fpos_ff) + 4'd1 == need_ff);
               end
               default: begin
                  fld_in = FD_DLC;
               end
            endcase
            if (fdone) begin
               fpos_in = 3'd0;
               if (fld_ff == FD_ID && dlc_ff[3:0] != 4'd0) begin
                  fld_in  = FD_DATA;
                  need_in = dlc_ff[3:0];
               end else if (fld_ff != FD_TS && dlc_ff[6]) begin
                  fld_in  = FD_TS;
                  need_in = 4'd2;
               end else begin
                  fld_in = FD_DLC;
                  st_in  = B_DELIV;
               end
            end
         end
         B_DELIV: begin
            if (nif_ok) begin
               if (dlc_ff[6]) begin
                  temit_in = 1'b1;
                  st_in    = B_TRD;
               end else begin
                  st_in = B_CEMIT;
               end
            end else begin
               st_in = B_PCHK;
            end
         end
         B_TRD: begin
            st_in = B_TUPD;
         end
         B_TUPD: begin
            t_wr    = 1'b1;
            tsum_in = 48'(tcur + {32'd0, ts_ff});
            st_in   = temit_ff ? B_CEMIT : B_FIN;
         end
         B_CEMIT: begin
            if (can_emit) begin
               emit_go             = 1'b1;
               emit_val.iface      = nif_ff[6:0];
               emit_val.can_id     = dlc_ff[5] ? id_ff[28:0] : {18'd0, id_ff[10:0]};
               emit_val.extended   = dlc_ff[5];
               emit_val.remote     = dlc_ff[4];
               emit_val.data_len   = dlc_ff[3:0];
               emit_val.data_bytes = data_ff;
               emit_val.has_time   = dlc_ff[6];
               emit_val.time_ticks = dlc_ff[6] ? tsum_ff : 48'd0;
               emit_val.event_code = EV_CAN;
               st_in               = B_PCHK;
            end
         end
         B_EV: begin
            if (can_emit) begin
               emit_go             = 1'b1;
               emit_val.event_code = evc_ff;
               emit_val.abort_code = ac_ff;
               st_in               = B_FIN;
            end
         end
         B_FIN: begin
            if (can_emit) begin
               fin_go     = 1'b1;
               frame_done = frm_ff;
               st_in      = B_IDLE;
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   // result staging: hold the newest result until the next one or the end of the beat
   always_comb begin
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      rcnt_in     = rcnt_ff;
      if (out_vld_ff && rsp_rdy) begin
         out_vld_in = 1'b0;
      end
      if (emit_go && rcnt_ff < RC_W'(MAX_RESULTS)) begin
         rcnt_in = RC_W'(rcnt_ff + 1'b1);
         if (hold_vld_ff) begin
            out_in      = hold_ff;
            out_in.last = 1'b0;
            out_vld_in  = 1'b1;
         end
         hold_in     = emit_val;
         hold_vld_in = 1'b1;
      end
      if (fin_go) begin
         rcnt_in = '0;
         if (hold_vld_ff) begin
            out_in      = hold_ff;
            out_in.last = 1'b1;
            out_vld_in  = 1'b1;
         end
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pwr.en) begin
         pmem[pwr.addr[PA_W-1:0]] <= pwr.data;
      end
      pq_ff <= pmem[idx_ff[PA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (t_wr) begin
         tmem[ti] <= tsum_in;
      end
      tq_ff  <= tmem[ti];
      tvq_ff <= tvld_ff[ti];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvld_ff <= '0;
      end else if (t_wr) begin
         tvld_ff[ti] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      fld_ff   <= fld_in;
      need_ff  <= need_in;
      fpos_ff  <= fpos_in;
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      typ_ff   <= typ_in;
      mlen_ff  <= mlen_in;
      mg_ff    <= mg_in;
      dlc_ff   <= dlc_in;
      nif_ff   <= nif_in;
      id_ff    <= id_in;
      data_ff  <= data_in;
      ts_ff    <= ts_in;
      tsum_ff  <= tsum_in;
      temit_ff <= temit_in;
      evc_ff   <= evc_in;
      ac_ff    <= ac_in;
      frm_ff   <= frm_in;
      hold_ff  <= hold_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= B_IDLE;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         rcnt_ff     <= '0;
      end else begin
         st_ff       <= st_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
         rcnt_ff     <= rcnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_fin_clears_hold: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> !hold_vld_ff)
      else $error("held result survived end of beat");
   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit_go |-> (!hold_vld_ff || !out_vld_ff || rsp_rdy))
      else $error("result emitted without room");
   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= RC_W'(MAX_RESULTS))
      else $error("result count above cap");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("pop from empty queue");
`endif

endmodule

// File: bench/tb_wireless_can_frame_receiver.sv
// Testbench of the wireless CAN frame receiver: directed and random byte streams,
// results predicted per byte and checked in order. Depends on wcfr_pkg, wcfr_req_if,
// wcfr_rsp_if and wireless_can_frame_receiver.
`timescale 1ns / 1ps

module tb_wireless_can_frame_receiver;
   import wcfr_pkg::*;

   localparam int PL_MAX      = 128;
   localparam int IFACE_MAX   = 127;
   localparam int BEAT_CAP    = PL_MAX / 3 + 2;
   localparam int SETTLE      = 800;
   localparam int CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;

   wcfr_req_if req_chan ();
   wcfr_rsp_if rsp_chan ();

   wireless_can_frame_receiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // receiver state mirror
   int          rx_pos;
   logic [7:0]  rx_len, rx_seq, rx_type, rx_crc_lo, seq_expected;
   logic [15:0] rx_crc;
   logic [7:0]  rx_store [PL_MAX];
   logic [47:0] iface_clock [IFACE_MAX];
   logic [6:0]  own_iface;

   rsl_type beat_results [$];
   rsl_type pending_results [$];

   int errors;
   int cycles;
   int bytes_sent;
   bit quiet;
   int hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

   function automatic logic [7:0] stored(input int i);
      return (i < PL_MAX) ? rx_store[i] : 8'h00;
   endfunction

   function automatic void add_result(input int iface, input logic [28:0] id, input bit ext,
                                      input bit rtr, input int dlen, input logic [63:0] data,
                                      input bit ht, input logic [47:0] tt,
                                      input ev_code_type ev, input logic [31:0] ac);
      rsl_type r;
      if (beat_results.size() >= BEAT_CAP)
         return;
      r.iface = iface[6:0];
      r.can_id = id;
      r.extended = ext;
      r.remote = rtr;
      r.data_len = dlen[3:0];
      r.data_bytes = data;
      r.has_time = ht;
      r.time_ticks = tt;
      r.event_code = ev;
      r.abort_code = ac;
      r.last = 1'b0;
      beat_results.push_back(r);
   endfunction

   function automatic void add_event(input ev_code_type ev, input logic [31:0] ac = 0);
      add_result(0, 0, 0, 0, 0, 0, 0, 0, ev, ac);
   endfunction

   function automatic void split_can_telegrams();
      int i, n, dl, nif;
      logic [7:0]  dlc;
      logic [28:0] id;
      logic [31:0] idw;
      logic [63:0] data;
      logic [47:0] t;
      bit ext, ht;
      i = 0;
      n = rx_len;
      while (i < n) begin
         dlc = stored(i);
         dl = dlc[3:0];
         ext = dlc[5];
         ht = dlc[6];
         nif = 1;
         data = 0;
         t = 0;
         i++;
         if (dl > 8) begin
            add_event(EV_TELEGRAM);
            return;
         end
         if (dlc[7]) begin
            if (n - i < 1) begin
               add_event(EV_TELEGRAM);
               return;
            end
            nif = stored(i);
            i++;
         end
         if (ext) begin
            if (n - i < 4) begin
               add_event(EV_TELEGRAM);
               return;
            end
            idw = {stored(i + 3), stored(i + 2), stored(i + 1), stored(i)};
            id = idw[28:0];
            i += 4;
         end else begin
            if (n - i < 2) begin
               add_event(EV_TELEGRAM);
               return;
            end
            idw = {16'd0, stored(i + 1), stored(i)};
            id = {18'd0, idw[10:0]};
            i += 2;
         end
         if (n - i < dl) begin
            add_event(EV_TELEGRAM);
            return;
         end
         for (int k = 0; k < dl; k++)
            data[8*k +: 8] = stored(i + k);
         i += dl;
         if (ht) begin
            if (n - i < 2) begin
               add_event(EV_TELEGRAM);
               return;
            end
            t = {stored(i + 1), stored(i)};
            i += 2;
         end
         if (nif == 0 || nif > IFACE_MAX)
            continue;
         if (ht) begin
            iface_clock[nif - 1] = iface_clock[nif - 1] + t;
            t = iface_clock[nif - 1];
         end
         add_result(nif, id, ext, dlc[4], dl, data, ht, ht ? t : 48'd0, EV_CAN, 0);
      end
   endfunction

   function automatic void close_frame(input logic [7:0] crc_hi);
      logic [7:0] ind;
      logic [31:0] ac;
      ind = stored(0);
      if ({crc_hi, rx_crc_lo} != rx_crc) begin
         add_event(EV_CRC);
         return;
      end
      if (rx_seq != seq_expected)
         add_event(EV_SEQ);
      seq_expected = rx_seq + 8'd1;
      case (rx_type)
         TYPE_CAN: begin
            split_can_telegrams();
         end
         TYPE_KEEP: begin
            if (rx_len < 1 || ind <= IND_BASE) add_event(EV_PAYLOAD);
         end
         TYPE_TIME: begin
            if (rx_len < 1 || ind == 0 || ind > IFACE_MAX)
               add_event(EV_PAYLOAD);
            else
               iface_clock[ind - 1] = iface_clock[ind - 1] + 48'd65535;
         end
         TYPE_DIAG0, TYPE_DIAG1, TYPE_DIAG2: begin
            add_event(EV_DIAG);
         end
         TYPE_ABORT: begin
            if (rx_len < 5 || ind <= IND_BASE) begin
               add_event(EV_PAYLOAD);
            end else if (ind == IND_BASE + own_iface) begin
               ac = {stored(4), stored(3), stored(2), stored(1)};
               if (ac != 0) add_event(EV_ABORT, ac);
            end
         end
         default: begin
            add_event(EV_TYPE);
         end
      endcase
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      int k;
      beat_results.delete();
      if (rx_pos == 0) begin
         if (b != PREAMBLE) begin
            add_event(EV_PREAMBLE);
         end else begin
            rx_crc = crc16_step(16'hFFFF, b);
            rx_pos = 1;
         end
      end else if (rx_pos == 1) begin
         rx_len = b;
         if (b > PL_MAX) begin
            add_event(EV_PAYLOAD);
            rx_pos = 0;
         end else begin
            rx_crc = crc16_step(rx_crc, b);
            rx_pos = 2;
         end
      end else if (rx_pos < 4) begin
         if (rx_pos == 2) rx_seq = b; else rx_type = b;
         rx_crc = crc16_step(rx_crc, b);
         rx_pos++;
      end else begin
         k = rx_pos - 4;
         if (k < rx_len) begin
            rx_store[k] = b;
            rx_crc = crc16_step(rx_crc, b);
            rx_pos++;
         end else if (k == rx_len) begin
            rx_crc_lo = b;
            rx_pos++;
         end else begin
            close_frame(b);
            rx_pos = 0;
         end
      end
      if (beat_results.size() > 0)
         beat_results[$].last = 1'b1;
      foreach (beat_results[j])
         pending_results.push_back(beat_results[j]);
   endfunction

   // result checker
   always @(posedge clock) begin
      rsl_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result: event %0d iface %0d", $time,
                     rsp_chan.event_code, rsp_chan.iface);
         end else begin
            e = pending_results.pop_front();
            if (rsp_chan.iface !== e.iface || rsp_chan.can_id !== e.can_id ||
                rsp_chan.extended !== e.extended || rsp_chan.remote !== e.remote ||
                rsp_chan.data_len !== e.data_len || rsp_chan.data_bytes !== e.data_bytes ||
                rsp_chan.has_time !== e.has_time || rsp_chan.time_ticks !== e.time_ticks ||
                rsp_chan.event_code !== e.event_code || rsp_chan.abort_code !== e.abort_code ||
                rsp_chan.last !== e.last) begin
               errors++;
               $display("%0t mismatch: expected if=%0d id=%h x=%b r=%b n=%0d d=%h t=%b/%h ev=%0d ac=%h l=%b",
                        $time, e.iface, e.can_id, e.extended, e.remote, e.data_len,
                        e.data_bytes, e.has_time, e.time_ticks, e.event_code,
                        e.abort_code, e.last);
               $display("%0t          actual   if=%0d id=%h x=%b r=%b n=%0d d=%h t=%b/%h ev=%0d ac=%h l=%b",
                        $time, rsp_chan.iface, rsp_chan.can_id, rsp_chan.extended,
                        rsp_chan.remote, rsp_chan.data_len, rsp_chan.data_bytes,
                        rsp_chan.has_time, rsp_chan.time_ticks, rsp_chan.event_code,
                        rsp_chan.abort_code, rsp_chan.last);
            end
         end
      end
   end

   // result ready with random stalls and requested long hold-offs
   always @(posedge clock) begin
      int hold_left;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet || ($urandom_range(99) >= 34);
         end
      end
   end

   // leave valid high after the beat; the next send or wait_idle drives it
   task automatic send_byte(input logic [7:0] b);
      while (!quiet && $urandom_range(99) < 34) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      predict_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] pl[$], input logic [7:0] seq,
                             input logic [7:0] ftype, input bit bad_crc = 0);
      logic [7:0]  hdr[$];
      logic [15:0] crc;
      hdr = {PREAMBLE, 8'(pl.size()), seq, ftype};
      hdr = {hdr, pl};
      crc = 16'hFFFF;
      foreach (hdr[i]) crc = crc16_step(crc, hdr[i]);
      if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
      hdr.push_back(crc[7:0]);
      hdr.push_back(crc[15:8]);
      foreach (hdr[i]) send_byte(hdr[i]);
   endtask

   function automatic void add_telegram(ref logic [7:0] pl[$], input logic [7:0] dlc,
                                        input logic [7:0] nif, input logic [31:0] id,
                                        input logic [63:0] data, input logic [15:0] t);
      pl.push_back(dlc);
      if (dlc[3:0] > 8) return;
      if (dlc[7]) pl.push_back(nif);
      pl.push_back(id[7:0]);
      pl.push_back(id[15:8]);
      if (dlc[5]) begin
         pl.push_back(id[23:16]);
         pl.push_back(id[31:24]);
      end
      for (int k = 0; k < dlc[3:0]; k++) pl.push_back(data[8*k +: 8]);
      if (dlc[6]) begin
         pl.push_back(t[7:0]);
         pl.push_back(t[15:8]);
      end
   endfunction

   function automatic void random_telegrams(ref logic [7:0] pl[$], input int count);
      logic [7:0] dlc, nif;
      for (int n = 0; n < count && pl.size() < 100; n++) begin
         dlc = {1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 4'($urandom_range(8))};
         if ($urandom_range(19) == 0) dlc[3:0] = 4'($urandom_range(15, 9));
         nif = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
         add_telegram(pl, dlc, nif, $urandom, {$urandom, $urandom}, 16'($urandom));
      end
      if ($urandom_range(9) == 0 && pl.size() > 0) void'(pl.pop_back());
   endfunction

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_own_iface(input logic [6:0] v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      own_iface = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic resync();
      while (rx_pos != 0) send_byte(8'($urandom));
   endtask

   task automatic test_framing_errors();
      logic [7:0] pl[$];
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(PREAMBLE);
      send_byte(8'd129);
      send_byte(PREAMBLE);
      send_byte(8'hFF);
      pl = {8'h01, 8'h02, 8'h03};
      send_frame(pl, seq_expected, TYPE_CAN, 1);
      pl = {};
      send_frame(pl, seq_expected + 8'd5, TYPE_CAN);
      send_frame(pl, seq_expected, 8'hFF);
   endtask

   task automatic test_can_frames();
      logic [7:0] pl[$];
      add_telegram(pl, 8'h08, 0, 32'h0000_07FF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      add_telegram(pl, 8'hF8, 8'd127, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 16'hFFFF);
      add_telegram(pl, 8'h90, 8'd2, 32'h0000_0123, 0, 0);
      add_telegram(pl, 8'hC1, 8'd2, 32'h0000_0001, 64'h5A, 16'h0001);
      add_telegram(pl, 8'h80, 8'd0, 32'h0000_0100, 0, 0);
      add_telegram(pl, 8'h80, 8'd128, 32'h0000_0100, 0, 0);
      send_frame(pl, seq_expected, TYPE_CAN);
      pl = {};
      add_telegram(pl, 8'h02, 0, 32'h55, 64'h1111, 0);
      add_telegram(pl, 8'h09, 0, 0, 0, 0);
      send_frame(pl, seq_expected, TYPE_CAN);
      pl = {};
      add_telegram(pl, 8'h24, 0, 32'h1234_5678, 64'h1, 0);
      void'(pl.pop_back());
      send_frame(pl, seq_expected, TYPE_CAN);
   endtask

   task automatic test_management_frames();
      logic [7:0] pl[$];
      pl = {8'h81};
      send_frame(pl, seq_expected, TYPE_KEEP);
      pl = {8'h80};
      send_frame(pl, seq_expected, TYPE_KEEP);
      pl = {};
      send_frame(pl, seq_expected, TYPE_KEEP);
      send_frame(pl, seq_expected, TYPE_TIME);
      pl = {8'd0};
      send_frame(pl, seq_expected, TYPE_TIME);
      pl = {8'd128};
      send_frame(pl, seq_expected, TYPE_TIME);
      pl = {8'd1};
      send_frame(pl, seq_expected, TYPE_TIME);
      pl = {};
      add_telegram(pl, 8'hC0, 8'd1, 32'h7, 0, 16'h0005);
      send_frame(pl, seq_expected, TYPE_CAN);
      pl = {};
      send_frame(pl, seq_expected, TYPE_DIAG0);
      send_frame(pl, seq_expected, TYPE_DIAG1);
      send_frame(pl, seq_expected, TYPE_DIAG2);
      pl = {IND_BASE + 8'(own_iface), 8'hEF, 8'hBE, 8'hAD, 8'hDE};
      send_frame(pl, seq_expected, TYPE_ABORT);
      pl = {IND_BASE + 8'(own_iface), 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame(pl, seq_expected, TYPE_ABORT);
      pl = {IND_BASE + 8'(own_iface) + 8'd1, 8'h01, 8'h00, 8'h00, 8'h00};
      send_frame(pl, seq_expected, TYPE_ABORT);
      pl = {IND_BASE, 8'h01, 8'h00, 8'h00, 8'h00};
      send_frame(pl, seq_expected, TYPE_ABORT);
      pl = {IND_BASE + 8'(own_iface), 8'h01, 8'h00, 8'h00};
      send_frame(pl, seq_expected, TYPE_ABORT);
   endtask

   task automatic test_back_pressure();
      logic [7:0] pl[$];
      hold_request = 600;
      for (int n = 0; n < 42; n++) add_telegram(pl, 8'h00, 0, $urandom, 0, 0);
      pl.push_back(8'h00);
      pl.push_back(8'h00);
      send_frame(pl, seq_expected + 8'd1, TYPE_CAN);
      pl = {};
      add_telegram(pl, 8'h01, 0, 32'h0000_0321, 64'hA5, 0);
      send_frame(pl, seq_expected, TYPE_CAN);
   endtask

   task automatic test_random_traffic(input int goal);
      logic [7:0] pl[$];
      logic [7:0] ftype;
      int start, pick;
      start = bytes_sent;
      while (bytes_sent - start < goal) begin
         quiet = ((bytes_sent - start) > goal / 3) && ((bytes_sent - start) < goal / 2);
         pick = $urandom_range(99);
         pl = {};
         if (pick < 60) begin
            random_telegrams(pl, $urandom_range(1, 5));
            send_frame(pl, ($urandom_range(9) == 0) ? 8'($urandom) : seq_expected,
                       TYPE_CAN, $urandom_range(14) == 0);
         end else if (pick < 80) begin
            ftype = 8'($urandom_range(8'h10, 8'h16));
            if ($urandom_range(9) == 0) ftype = 8'($urandom);
            pl.push_back($urandom_range(1) ? IND_BASE + 8'(own_iface) : 8'($urandom));
            repeat ($urandom_range(5)) pl.push_back(8'($urandom));
            if ($urandom_range(7) == 0) pl = {};
            send_frame(pl, seq_expected, ftype, $urandom_range(14) == 0);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            resync();
         end
      end
      quiet = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      csr_wr_en = 1'b0;
      csr_wr_data = 7'd0;
      errors = 0;
      cycles = 0;
      bytes_sent = 0;
      quiet = 0;
      hold_request = 0;
      rx_pos = 0;
      rx_len = 0;
      rx_seq = 0;
      rx_type = 0;
      rx_crc = 16'hFFFF;
      rx_crc_lo = 0;
      seq_expected = 0;
      own_iface = 7'd1;
      foreach (iface_clock[i]) iface_clock[i] = 0;
      foreach (rx_store[i]) rx_store[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_framing_errors();
      test_can_frames();
      test_management_frames();
      test_back_pressure();
      write_own_iface(7'd127);
      test_random_traffic(30);

      wait_idle();
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
